// ===== hdl/ikc_pkg.sv =====
`default_nettype none

package ikc_pkg;

  // Key classes as they arrive on the input stream.
  localparam logic [3:0] KEY_DIGIT  = 4'd0;
  localparam logic [3:0] KEY_DOT    = 4'd1;
  localparam logic [3:0] KEY_ADD    = 4'd2;
  localparam logic [3:0] KEY_SUB    = 4'd3;
  localparam logic [3:0] KEY_MUL    = 4'd4;
  localparam logic [3:0] KEY_DIV    = 4'd5;
  localparam logic [3:0] KEY_OPEN   = 4'd6;
  localparam logic [3:0] KEY_CLOSE  = 4'd7;
  localparam logic [3:0] KEY_EQUALS = 4'd8;
  localparam logic [3:0] KEY_CLEAR  = 4'd9;
  localparam logic [3:0] KEY_BACK   = 4'd10;
  localparam logic [3:0] KEY_NEGATE = 4'd11;
  localparam logic [3:0] KEY_MC     = 4'd12;
  localparam logic [3:0] KEY_MR     = 4'd13;
  localparam logic [3:0] KEY_MPLUS  = 4'd14;
  localparam logic [3:0] KEY_MMINUS = 4'd15;

  // Codes held on the operator stack.
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_OPEN = 3'd5;

  // Kind of the previous key.
  localparam logic [2:0] KIND_CLEARED = 3'd0;
  localparam logic [2:0] KIND_DIGIT   = 3'd1;
  localparam logic [2:0] KIND_MULDIV  = 3'd2;
  localparam logic [2:0] KIND_ADDSUB  = 3'd3;
  localparam logic [2:0] KIND_OTHER   = 3'd4;

  localparam logic [3:0]  CHAR_DOT = 4'd10;
  localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

  // Signed result with a flag that tells whether it fits the format.
  typedef struct packed {
    logic        ok;
    logic [63:0] value;
  } fx_res_t;

  function automatic logic [63:0] fx_magnitude(logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic fx_res_t fx_from_mag(logic [63:0] m, logic neg);
    fx_res_t r;
    r.ok    = neg ? (m <= SIGN_BIT) : (m < SIGN_BIT);
    r.value = neg ? (~m + 64'd1) : m;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/infix_key_calculator.sv =====
// A digit or dot key rebuilds the value from the entry, with a serial divide by ten
// per fraction digit. Reducing a multiply or divide takes longer than an add or subtract,
// set by the bit-serial multiplier and the shared divider (one bit per cycle).
// One key is processed at a time; a new request is taken while a result waits.
// Reset is asynchronous and active low; it clears all control state and the stacks' counts.
`default_nettype none

module infix_key_calculator #(
  parameter int VALUE_DEPTH    = 16,
  parameter int OPERATOR_DEPTH = 16,
  parameter int ENTRY_CHARS    = 12,
  parameter int FRACTION_BITS  = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [3:0] key_class, [7:4] digit
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [71:0]      m_axis_tdata_o    // [63:0] shown_value, [64] error,
                                             // [65] memory_nonzero, rest zero
);
  import ikc_pkg::*;

  localparam int VAW = $clog2(VALUE_DEPTH);
  localparam int VCW = $clog2(VALUE_DEPTH + 1);
  localparam int OAW = $clog2(OPERATOR_DEPTH);
  localparam int OCW = $clog2(OPERATOR_DEPTH + 1);
  localparam int EAW = (ENTRY_CHARS > 1) ? $clog2(ENTRY_CHARS) : 1;
  localparam int ECW = $clog2(ENTRY_CHARS + 1);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_EXEC    = 4'd1;
  localparam logic [3:0] ST_PEEK    = 4'd2;
  localparam logic [3:0] ST_CHECK   = 4'd3;
  localparam logic [3:0] ST_APPLY   = 4'd4;
  localparam logic [3:0] ST_OPERATE = 4'd5;
  localparam logic [3:0] ST_MULW    = 4'd6;
  localparam logic [3:0] ST_DIVW    = 4'd7;
  localparam logic [3:0] ST_PUSH    = 4'd8;
  localparam logic [3:0] ST_PINT    = 4'd9;
  localparam logic [3:0] ST_PFRAC   = 4'd10;
  localparam logic [3:0] ST_PFWAIT  = 4'd11;
  localparam logic [3:0] ST_PEND    = 4'd12;
  localparam logic [3:0] ST_DONE    = 4'd13;

  logic [3:0]     state_q, state_d;
  logic [3:0]     key_q, key_d, dig_q, dig_d;
  logic [VCW-1:0] vc_q, vc_d;
  logic [OCW-1:0] opc_q, opc_d;
  logic [63:0]    cur_q, cur_d, mem_q, mem_d;
  logic [2:0]     prev_q, prev_d;
  logic [ECW-1:0] len_q, len_d, dotpos_q, dotpos_d, idx_q, idx_d;
  logic           dotv_q, dotv_d, err_q, err_d;
  logic [63:0]    ip_q, ip_d, frac_q, frac_d;
  logic [2:0]     curop_q, curop_d;
  logic           popok_q, popok_d, negd_q, negd_d;
  logic           m_valid_q, m_valid_d;
  logic [71:0]    m_data_q, m_data_d;

  // Stacks and the entry buffer.
  logic [63:0]    vmem [VALUE_DEPTH];
  logic [2:0]     omem [OPERATOR_DEPTH];
  logic [3:0]     emem [ENTRY_CHARS];
  logic [63:0]    vs_rd_q;
  logic [2:0]     op_rd_q;
  logic           v_we, o_we, e_we;
  logic [VAW-1:0] v_wa, v_ra;
  logic [OAW-1:0] o_wa, o_ra;
  logic [EAW-1:0] e_wa, e_ra;
  logic [2:0]     o_wd;
  logic [3:0]     e_wd, ent_rd;
  logic [VCW-1:0] vc_m1;
  logic [OCW-1:0] opc_m1;
  logic [ECW-1:0] idx_m1;

  // Arithmetic units.
  logic           mul_start, mul_done, div_start, div_done;
  fx_res_t        mul_res, div_res;
  logic [63:0]    div_rem, div_low, div_den, div_quo;

  // Helper values.
  logic [63:0]    left_v, add_r, sub_r, ma_l, mb_c, madd_r, msub_r, ip10, frac_x;
  logic           add_ok, sub_ok, madd_ok, msub_ok, div_pre_fail;
  logic [ECW-1:0] dot_end;
  logic           fresh, is_opkey;
  logic [ECW-1:0] len_eff, len_m1;
  logic           ap_valid, ap_ok;
  logic [63:0]    ap_val;
  logic           red;

  assign vc_m1  = vc_q - VCW'(1);
  assign opc_m1 = opc_q - OCW'(1);
  assign idx_m1 = idx_q - ECW'(1);
  assign v_ra   = vc_m1[VAW-1:0];
  assign o_ra   = opc_m1[OAW-1:0];
  assign e_ra   = (state_q == ST_PINT) ? idx_q[EAW-1:0] : idx_m1[EAW-1:0];
  assign ent_rd = emem[e_ra];

  // Operand and flag helpers.
  assign left_v  = popok_q ? vs_rd_q : 64'd0;
  assign add_r   = left_v + cur_q;
  assign sub_r   = left_v - cur_q;
  assign add_ok  = ~(~(left_v[63] ^ cur_q[63]) & (left_v[63] ^ add_r[63]));
  assign sub_ok  = ~((left_v[63] ^ cur_q[63]) & (left_v[63] ^ sub_r[63]));
  assign madd_r  = mem_q + cur_q;
  assign msub_r  = mem_q - cur_q;
  assign madd_ok = ~(~(mem_q[63] ^ cur_q[63]) & (mem_q[63] ^ madd_r[63]));
  assign msub_ok = ~((mem_q[63] ^ cur_q[63]) & (mem_q[63] ^ msub_r[63]));
  assign ma_l    = fx_magnitude(left_v);
  assign mb_c    = fx_magnitude(cur_q);
  assign div_pre_fail = (ma_l >> (64 - FRACTION_BITS)) >= mb_c;
  assign ip10    = (ip_q << 3) + (ip_q << 1) + {60'd0, ent_rd};
  assign frac_x  = ({60'd0, ent_rd} << FRACTION_BITS) + frac_q;
  assign dot_end = dotv_q ? dotpos_q : len_q;
  assign fresh   = (prev_q != KIND_DIGIT) || err_q;
  assign len_eff = fresh ? '0 : len_q;
  assign len_m1  = len_q - ECW'(1);
  assign is_opkey = (key_q == KEY_ADD) || (key_q == KEY_SUB) ||
                    (key_q == KEY_MUL) || (key_q == KEY_DIV);

  // The divider serves both the fixed-point divide and the divide by ten of the entry.
  assign div_rem = (state_q == ST_OPERATE) ? (ma_l >> (64 - FRACTION_BITS)) : 64'd0;
  assign div_low = (state_q == ST_OPERATE) ? (ma_l << FRACTION_BITS) : frac_x;
  assign div_den = (state_q == ST_OPERATE) ? mb_c : 64'd10;
  assign div_res = fx_from_mag(div_quo, negd_q);

  ikc_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .a_i      (left_v),
    .b_i      (cur_q),
    .done_o   (mul_done),
    .result_o (mul_res)
  );

  ikc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (div_rem),
    .low_i   (div_low),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Reduction test for the operator on top of the stack.
  always_comb begin
    case (key_q)
      KEY_CLOSE:  red = (op_rd_q != OP_OPEN);
      KEY_EQUALS: red = 1'b1;
      default:    red = (op_rd_q == OP_MUL) || (op_rd_q == OP_DIV) ||
                        (((key_q == KEY_ADD) || (key_q == KEY_SUB)) &&
                         ((op_rd_q == OP_ADD) || (op_rd_q == OP_SUB)));
    endcase
  end

  // Key sequencer.
  always_comb begin
    state_d   = state_q;
    key_d     = key_q;
    dig_d     = dig_q;
    vc_d      = vc_q;
    opc_d     = opc_q;
    cur_d     = cur_q;
    mem_d     = mem_q;
    prev_d    = prev_q;
    len_d     = len_q;
    dotpos_d  = dotpos_q;
    dotv_d    = dotv_q;
    err_d     = err_q;
    idx_d     = idx_q;
    ip_d      = ip_q;
    frac_d    = frac_q;
    curop_d   = curop_q;
    popok_d   = popok_q;
    negd_d    = negd_q;
    m_valid_d = m_valid_q & ~m_axis_tready_i;
    m_data_d  = m_data_q;
    v_we      = 1'b0;
    v_wa      = vc_q[VAW-1:0];
    o_we      = 1'b0;
    o_wa      = opc_q[OAW-1:0];
    o_wd      = OP_OPEN;
    e_we      = 1'b0;
    e_wa      = '0;
    e_wd      = 4'd0;
    mul_start = 1'b0;
    div_start = 1'b0;
    ap_valid  = 1'b0;
    ap_ok     = 1'b0;
    ap_val    = 64'd0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          key_d   = s_axis_tdata_i[3:0];
          dig_d   = s_axis_tdata_i[7:4];
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_d = ST_DONE;
        case (key_q)
          KEY_DIGIT, KEY_DOT: begin
            if (!((key_q == KEY_DIGIT) && (dig_q > 4'd9))) begin
              if (fresh) begin
                err_d = 1'b0;
              end
              len_d  = len_eff;
              dotv_d = fresh ? 1'b0 : dotv_q;
              if (len_eff < ECW'(ENTRY_CHARS)) begin
                if (key_q == KEY_DIGIT) begin
                  e_we  = 1'b1;
                  e_wa  = len_eff[EAW-1:0];
                  e_wd  = dig_q;
                  len_d = len_eff + ECW'(1);
                end else if (!dotv_d) begin
                  e_we     = 1'b1;
                  e_wa     = len_eff[EAW-1:0];
                  e_wd     = CHAR_DOT;
                  dotv_d   = 1'b1;
                  dotpos_d = len_eff;
                  len_d    = len_eff + ECW'(1);
                end
              end
              prev_d  = KIND_DIGIT;
              idx_d   = '0;
              ip_d    = 64'd0;
              state_d = ST_PINT;
            end
          end
          KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV: begin
            prev_d  = ((key_q == KEY_ADD) || (key_q == KEY_SUB)) ? KIND_ADDSUB : KIND_MULDIV;
            state_d = ST_PEEK;
          end
          KEY_OPEN: begin
            if (opc_q < OCW'(OPERATOR_DEPTH)) begin
              o_we  = 1'b1;
              o_wd  = OP_OPEN;
              opc_d = opc_q + OCW'(1);
            end else begin
              err_d = 1'b1;
            end
            prev_d = KIND_OTHER;
          end
          KEY_CLOSE, KEY_EQUALS: begin
            prev_d  = KIND_OTHER;
            state_d = ST_PEEK;
          end
          KEY_CLEAR: begin
            e_we   = 1'b1;
            len_d  = ECW'(1);
            cur_d  = 64'd0;
            err_d  = 1'b0;
            dotv_d = 1'b0;
            if (prev_q != KIND_CLEARED) begin
              prev_d = KIND_CLEARED;
            end else begin
              vc_d   = '0;
              opc_d  = '0;
              mem_d  = 64'd0;
              prev_d = KIND_OTHER;
            end
          end
          KEY_BACK: begin
            prev_d = KIND_DIGIT;
            if (fresh || (len_m1 == '0)) begin
              e_we   = 1'b1;
              len_d  = ECW'(1);
              cur_d  = 64'd0;
              err_d  = 1'b0;
              dotv_d = 1'b0;
            end else begin
              len_d = len_m1;
              if (dotv_q && (dotpos_q >= len_m1)) begin
                dotv_d = 1'b0;
              end
              idx_d   = '0;
              ip_d    = 64'd0;
              state_d = ST_PINT;
            end
          end
          KEY_NEGATE: begin
            if (cur_q == SIGN_BIT) begin
              err_d = 1'b1;
            end else begin
              cur_d = ~cur_q + 64'd1;
              err_d = 1'b0;
            end
            prev_d = KIND_OTHER;
          end
          KEY_MC: begin
            mem_d  = 64'd0;
            prev_d = KIND_OTHER;
          end
          KEY_MR: begin
            cur_d  = mem_q;
            err_d  = 1'b0;
            prev_d = KIND_OTHER;
          end
          KEY_MPLUS: begin
            if (madd_ok) mem_d = madd_r;
            else err_d = 1'b1;
            prev_d = KIND_OTHER;
          end
          default: begin
            if (msub_ok) mem_d = msub_r;
            else err_d = 1'b1;
            prev_d = KIND_OTHER;
          end
        endcase
      end

      ST_PEEK: begin
        if (opc_q != '0) begin
          state_d = ST_CHECK;
        end else if (is_opkey) begin
          state_d = ST_PUSH;
        end else begin
          if (key_q == KEY_CLOSE) err_d = 1'b1;
          state_d = ST_DONE;
        end
      end

      ST_CHECK: begin
        if (red) begin
          opc_d   = opc_m1;
          curop_d = op_rd_q;
          state_d = ST_APPLY;
        end else if (is_opkey) begin
          state_d = ST_PUSH;
        end else begin
          opc_d   = opc_m1;
          state_d = ST_DONE;
        end
      end

      ST_APPLY: begin
        if ((curop_q != OP_ADD) && (curop_q != OP_SUB) &&
            (curop_q != OP_MUL) && (curop_q != OP_DIV)) begin
          state_d = ST_PEEK;
        end else if ((curop_q == OP_DIV) && (cur_q == 64'd0)) begin
          err_d   = 1'b1;
          state_d = ST_PEEK;
        end else begin
          if (vc_q != '0) begin
            vc_d    = vc_m1;
            popok_d = 1'b1;
          end else begin
            err_d   = 1'b1;
            popok_d = 1'b0;
          end
          state_d = ST_OPERATE;
        end
      end

      ST_OPERATE: begin
        negd_d = left_v[63] ^ cur_q[63];
        case (curop_q)
          OP_ADD: begin
            ap_valid = 1'b1;
            ap_ok    = add_ok;
            ap_val   = add_r;
          end
          OP_SUB: begin
            ap_valid = 1'b1;
            ap_ok    = sub_ok;
            ap_val   = sub_r;
          end
          OP_MUL: begin
            mul_start = 1'b1;
            state_d   = ST_MULW;
          end
          default: begin
            if (div_pre_fail) begin
              ap_valid = 1'b1;
              ap_ok    = 1'b0;
            end else begin
              div_start = 1'b1;
              state_d   = ST_DIVW;
            end
          end
        endcase
      end

      ST_MULW: begin
        if (mul_done) begin
          ap_valid = 1'b1;
          ap_ok    = mul_res.ok;
          ap_val   = mul_res.value;
        end
      end

      ST_DIVW: begin
        if (div_done) begin
          ap_valid = 1'b1;
          ap_ok    = div_res.ok;
          ap_val   = div_res.value;
        end
      end

      ST_PUSH: begin
        if (opc_q < OCW'(OPERATOR_DEPTH)) begin
          o_we  = 1'b1;
          o_wd  = key_q[2:0] - 3'd1;
          opc_d = opc_q + OCW'(1);
        end else begin
          err_d = 1'b1;
        end
        if (vc_q < VCW'(VALUE_DEPTH)) begin
          v_we = 1'b1;
          vc_d = vc_q + VCW'(1);
        end else begin
          err_d = 1'b1;
        end
        state_d = ST_DONE;
      end

      ST_PINT: begin
        if (idx_q < dot_end) begin
          ip_d  = ip10;
          idx_d = idx_q + ECW'(1);
        end else begin
          idx_d   = len_q;
          frac_d  = 64'd0;
          state_d = ST_PFRAC;
        end
      end

      ST_PFRAC: begin
        if (dotv_q && ({1'b0, idx_q} > ({1'b0, dotpos_q} + (ECW + 1)'(1)))) begin
          div_start = 1'b1;
          state_d   = ST_PFWAIT;
        end else begin
          state_d = ST_PEND;
        end
      end

      ST_PFWAIT: begin
        if (div_done) begin
          frac_d  = div_quo;
          idx_d   = idx_m1;
          state_d = ST_PFRAC;
        end
      end

      ST_PEND: begin
        if ((ip_q >> (63 - FRACTION_BITS)) != 64'd0) begin
          err_d = 1'b1;
        end else begin
          cur_d = (ip_q << FRACTION_BITS) | frac_q;
        end
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {6'd0, (mem_q != 64'd0), err_q, (err_q ? 64'd0 : cur_q)};
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Close out one applied operator.
    if (ap_valid) begin
      if (!ap_ok) begin
        err_d = 1'b1;
      end else if (!err_q) begin
        cur_d = ap_val;
      end
      state_d = ST_PEEK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      vc_q      <= '0;
      opc_q     <= '0;
      cur_q     <= 64'd0;
      mem_q     <= 64'd0;
      prev_q    <= KIND_CLEARED;
      len_q     <= ECW'(1);
      dotv_q    <= 1'b0;
      err_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      vc_q      <= vc_d;
      opc_q     <= opc_d;
      cur_q     <= cur_d;
      mem_q     <= mem_d;
      prev_q    <= prev_d;
      len_q     <= len_d;
      dotv_q    <= dotv_d;
      err_q     <= err_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    dig_q    <= dig_d;
    dotpos_q <= dotpos_d;
    idx_q    <= idx_d;
    ip_q     <= ip_d;
    frac_q   <= frac_d;
    curop_q  <= curop_d;
    popok_q  <= popok_d;
    negd_q   <= negd_d;
    m_data_q <= m_data_d;
  end

  // Value stack: one write and one registered read at the top.
  always_ff @(posedge clk_i) begin
    if (v_we) vmem[v_wa] <= cur_q;
    vs_rd_q <= vmem[v_ra];
  end

  // Operator stack.
  always_ff @(posedge clk_i) begin
    if (o_we) omem[o_wa] <= o_wd;
    op_rd_q <= omem[o_ra];
  end

  // Entry characters.
  always_ff @(posedge clk_i) begin
    if (e_we) emem[e_wa] <= e_wd;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // Stack counts never pass their depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q <= VCW'(VALUE_DEPTH))
    else $error("value stack count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    opc_q <= OCW'(OPERATOR_DEPTH))
    else $error("operator stack count beyond depth");

  // A result that flags an error shows zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_data_q[64]) |-> (m_data_q[63:0] == 64'd0))
    else $error("error result shows a nonzero value");

  // A new result is loaded only when the output slot is free or being taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && m_valid_q && !m_axis_tready_i) |=> (state_q == ST_DONE))
    else $error("result overwritten while still pending");

endmodule

`default_nettype wire

// ===== hdl/ikc_mul.sv =====
`default_nettype none

module ikc_mul #(
  parameter int FRACTION_BITS = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [63:0]      a_i,
  input  wire logic [63:0]      b_i,
  output logic                  done_o,
  output ikc_pkg::fx_res_t      result_o
);
  import ikc_pkg::*;

  logic [127:0] prod_q, prod_d;
  logic [63:0]  ma_q, ma_d;
  logic         neg_q, neg_d;
  logic [5:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic [64:0]  sum;
  logic         hi_ovf;
  fx_res_t      fm;

  // One multiplier bit per cycle: add the multiplicand, then shift right.
  assign sum = {1'b0, prod_q[127:64]} + (prod_q[0] ? {1'b0, ma_q} : 65'd0);

  always_comb begin
    prod_d = prod_q;
    ma_d   = ma_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      prod_d = {64'd0, fx_magnitude(b_i)};
      ma_d   = fx_magnitude(a_i);
      neg_d  = a_i[63] ^ b_i[63];
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      prod_d = {sum, prod_q[63:1]};
      cnt_d  = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    ma_q   <= ma_d;
    neg_q  <= neg_d;
  end

  // Integer bits above the format mean overflow.
  assign hi_ovf = |prod_q[127:64+FRACTION_BITS];
  assign fm     = fx_from_mag(prod_q[FRACTION_BITS +: 64], neg_q);

  assign done_o         = done_q;
  assign result_o.ok    = fm.ok & ~hi_ovf;
  assign result_o.value = fm.value;

endmodule

`default_nettype wire

// ===== hdl/ikc_div.sv =====
`default_nettype none

module ikc_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] rem_i,
  input  wire logic [63:0] low_i,
  input  wire logic [63:0] den_i,
  output logic             done_o,
  output logic [63:0]      quo_o
);
  import ikc_pkg::*;

  logic [63:0] rem_q, rem_d, low_q, low_d, den_q, den_d, quo_q, quo_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [63:0] rem_sh;
  logic        take;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh = {rem_q[62:0], low_q[63]};
  assign take   = rem_q[63] | (rem_sh >= den_q);

  always_comb begin
    rem_d  = rem_q;
    low_d  = low_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = rem_i;
      low_d  = low_i;
      den_d  = den_i;
      quo_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = take ? (rem_sh - den_q) : rem_sh;
      low_d = {low_q[62:0], 1'b0};
      quo_d = {quo_q[62:0], take};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire
